FILE: hdl/sql_shape_fingerprint_hash_unit_defines.svh
// Assertion macros for the fingerprint hash unit controller.
`ifndef SQL_SHAPE_FINGERPRINT_HASH_UNIT_DEFINES_SVH
`define SQL_SHAPE_FINGERPRINT_HASH_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define SSF_ASSERT(lbl, clk_i, rstn_i, prop) \
    lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) prop) \
        else $error("ssf assertion failed");
// Check a property on every clock edge, reset included.
`define SSF_ASSERT_ALWAYS(lbl, clk_i, prop) \
    lbl: assert property (@(posedge clk_i) prop) \
        else $error("ssf assertion failed");
`else
`define SSF_ASSERT(lbl, clk_i, rstn_i, prop)
`define SSF_ASSERT_ALWAYS(lbl, clk_i, prop)
`endif
`endif

FILE: hdl/ssf_pkg.sv
// Package: lexer state, command/status types and the per-byte lexer functions.
package ssf_pkg;

    localparam int MAX_BYTES = 4096;
    localparam int BYTES_W   = $clog2(MAX_BYTES + 1);
    localparam int QDEPTH    = 8;

    localparam logic [63:0] FNV_BASIS = 64'd14695981039346656037;

    typedef enum logic [3:0] {
        M_IDLE       = 4'd0,
        M_LINE       = 4'd1,
        M_BLOCK      = 4'd2,
        M_BLOCK_STAR = 4'd3,
        M_IDENT      = 4'd4,
        M_NUMBER     = 4'd5,
        M_STRING     = 4'd6,
        M_STRING_Q   = 4'd7,
        M_QPARAM     = 4'd8,
        M_VAR        = 4'd9,
        M_VAR_COLON  = 4'd10,
        M_VAR_PAREN  = 4'd11
    } lex_mode_t;

    localparam logic [2:0] K_IDENT = 3'd0;
    localparam logic [2:0] K_NUM   = 3'd1;
    localparam logic [2:0] K_STR   = 3'd2;
    localparam logic [2:0] K_PARAM = 3'd3;
    localparam logic [2:0] K_SYM   = 3'd4;

    localparam logic [1:0] LK_NONE = 2'd0;
    localparam logic [1:0] LK_NUM  = 2'd1;
    localparam logic [1:0] LK_STR  = 2'd2;

    localparam logic [7:0] TOK_END   = 8'h00;
    localparam logic [7:0] TOK_NUM   = 8'h01;
    localparam logic [7:0] TOK_STR   = 8'h02;
    localparam logic [7:0] TOK_LIST  = 8'h04;
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;

    typedef struct packed {
        lex_mode_t   mode;
        logic        quote_is_double;
        logic [7:0]  held_byte;
        logic        held_valid;
        logic        comma_pending;
        logic [1:0]  list_kind;
        logic        list_folded;
        logic        name_seen;
        logic        error_seen;
    } lex_t;

    localparam lex_t LEX_RESET = '{mode: M_IDLE, quote_is_double: 1'b0, held_byte: 8'h00,
                                   held_valid: 1'b0, comma_pending: 1'b0,
                                   list_kind: LK_NONE, list_folded: 1'b0,
                                   name_seen: 1'b0, error_seen: 1'b0};

    // Lexer state plus the hash bytes one step emits.
    typedef struct packed {
        lex_t                   s;
        logic [QDEPTH-1:0][7:0] q;
        logic [3:0]             n;
    } ctx_t;

    typedef struct packed {
        logic load_feed;
        logic load_fin;
        logic mix;
        logic publish;
    } ssf_cmd_t;

    typedef struct packed {
        logic mix_done;
        logic out_busy;
    } ssf_status_t;

    function automatic logic is_space(logic [7:0] b);
        return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic logic is_id_start(logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) || (b == 8'h5F);
    endfunction

    function automatic logic is_digit(logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic is_id_char(logic [7:0] b);
        return is_id_start(b) || is_digit(b);
    endfunction

    function automatic logic is_var_char(logic [7:0] b);
        return is_id_char(b) || (b == CH_DOLLAR) || b[7];
    endfunction

    function automatic logic [7:0] to_lower(logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) ? (b + 8'd32) : b;
    endfunction

    // FNV-1a round; the prime is 2^40 + 2^8 + 0xB3, so shifts and adds suffice.
    function automatic logic [63:0] fnv_mix(logic [63:0] h, logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

    function automatic ctx_t emit(ctx_t c, logic [7:0] b);
        ctx_t r;
        r = c;
        r.q[r.n[2:0]] = b;
        r.n = r.n + 4'd1;
        return r;
    endfunction

    function automatic ctx_t token_begin(ctx_t c, logic [2:0] kind, logic [7:0] sym);
        ctx_t r;
        r = c;
        if (r.s.comma_pending) begin
            if ((kind == K_NUM && r.s.list_kind == LK_NUM) ||
                (kind == K_STR && r.s.list_kind == LK_STR)) begin
                if (!r.s.list_folded) begin
                    r = emit(r, TOK_LIST);
                    r = emit(r, TOK_END);
                    r.s.list_folded = 1'b1;
                end
                r.s.comma_pending = 1'b0;
                return r;
            end
            r = emit(r, CH_COMMA);
            r = emit(r, TOK_END);
            r.s.comma_pending = 1'b0;
            r.s.list_kind     = LK_NONE;
            r.s.list_folded   = 1'b0;
        end
        if (kind == K_SYM && sym == CH_COMMA && r.s.list_kind != LK_NONE) begin
            r.s.comma_pending = 1'b1;
            return r;
        end
        if (kind == K_NUM) begin
            r = emit(r, TOK_NUM);
            r = emit(r, TOK_END);
        end else if (kind == K_STR) begin
            r = emit(r, TOK_STR);
            r = emit(r, TOK_END);
        end else if (kind == K_SYM) begin
            r = emit(r, sym);
            r = emit(r, TOK_END);
        end
        r.s.list_kind = (kind == K_NUM) ? LK_NUM : (kind == K_STR) ? LK_STR : LK_NONE;
        r.s.list_folded = 1'b0;
        return r;
    endfunction

    function automatic ctx_t start_token(ctx_t c, logic [7:0] b);
        ctx_t r;
        r = c;
        if (b == CH_NUL) begin
            r.s.error_seen = 1'b1;
        end else if (is_id_start(b)) begin
            r = token_begin(r, K_IDENT, CH_NUL);
            r = emit(r, to_lower(b));
            r.s.mode = M_IDENT;
        end else if (is_digit(b)) begin
            r = token_begin(r, K_NUM, CH_NUL);
            r.s.mode = M_NUMBER;
        end else if (b == CH_SQUOTE || b == CH_DQUOTE) begin
            r = token_begin(r, K_STR, CH_NUL);
            r.s.quote_is_double = (b == CH_DQUOTE);
            r.s.mode = M_STRING;
        end else if (b == CH_QMARK) begin
            r = token_begin(r, K_PARAM, CH_NUL);
            r = emit(r, b);
            r.s.mode = M_QPARAM;
        end else if (b == CH_AT || b == CH_COLON || b == CH_DOLLAR) begin
            r = token_begin(r, K_PARAM, CH_NUL);
            r = emit(r, b);
            r.s.name_seen = 1'b0;
            r.s.mode = M_VAR;
        end else begin
            r = token_begin(r, K_SYM, b);
        end
        return r;
    endfunction

    function automatic ctx_t idle_byte(ctx_t c, logic [7:0] b);
        ctx_t       r;
        logic [7:0] h;
        r = c;
        r.s.mode = M_IDLE;
        if (r.s.held_valid) begin
            h = r.s.held_byte;
            r.s.held_valid = 1'b0;
            r.s.held_byte  = 8'h00;
            if (h == CH_DASH && b == CH_DASH) begin
                r.s.mode = M_LINE;
                return r;
            end
            if (h == CH_SLASH && b == CH_STAR) begin
                r.s.mode = M_BLOCK;
                return r;
            end
            r = token_begin(r, K_SYM, h);
        end
        if (is_space(b)) begin
            return r;
        end
        if (b == CH_DASH || b == CH_SLASH) begin
            r.s.held_byte  = b;
            r.s.held_valid = 1'b1;
            return r;
        end
        return start_token(r, b);
    endfunction

    function automatic ctx_t end_var(ctx_t c);
        ctx_t r;
        r = c;
        if (!r.s.name_seen) begin
            r.s.error_seen = 1'b1;
        end else begin
            r = emit(r, TOK_END);
            r.s.mode = M_IDLE;
        end
        return r;
    endfunction

    function automatic ctx_t var_byte(ctx_t c, logic [7:0] b);
        ctx_t r;
        r = c;
        if (b == CH_NUL) begin
            r.s.error_seen = 1'b1;
        end else if (is_var_char(b)) begin
            r = emit(r, b);
            r.s.name_seen = 1'b1;
        end else if (b == CH_LPAREN && r.s.name_seen) begin
            r = emit(r, b);
            r.s.mode = M_VAR_PAREN;
        end else if (b == CH_COLON) begin
            r.s.mode = M_VAR_COLON;
        end else begin
            r = end_var(r);
            if (!r.s.error_seen) begin
                r = idle_byte(r, b);
            end
        end
        return r;
    endfunction

    // One text byte through the lexer.
    function automatic ctx_t lex_feed(ctx_t c, logic [7:0] b);
        ctx_t       r;
        logic [7:0] qch;
        r = c;
        qch = r.s.quote_is_double ? CH_DQUOTE : CH_SQUOTE;
        if (r.s.error_seen) begin
            return r;
        end
        case (r.s.mode)
            M_LINE: begin
                if (b == CH_LF) r.s.mode = M_IDLE;
            end
            M_BLOCK: begin
                if (b == CH_STAR) r.s.mode = M_BLOCK_STAR;
            end
            M_BLOCK_STAR: begin
                if (b == CH_SLASH) r.s.mode = M_IDLE;
                else if (b != CH_STAR) r.s.mode = M_BLOCK;
            end
            M_IDENT: begin
                if (is_id_char(b)) begin
                    r = emit(r, to_lower(b));
                end else begin
                    r = emit(r, TOK_END);
                    r = idle_byte(r, b);
                end
            end
            M_NUMBER: begin
                if (!is_digit(b)) r = idle_byte(r, b);
            end
            M_STRING: begin
                if (b == CH_NUL) r.s.error_seen = 1'b1;
                else if (b == qch) r.s.mode = M_STRING_Q;
            end
            M_STRING_Q: begin
                if (b == qch) r.s.mode = M_STRING;
                else r = idle_byte(r, b);
            end
            M_QPARAM: begin
                if (is_digit(b)) begin
                    r = emit(r, b);
                end else begin
                    r = emit(r, TOK_END);
                    r = idle_byte(r, b);
                end
            end
            M_VAR: begin
                r = var_byte(r, b);
            end
            M_VAR_COLON: begin
                if (b == CH_COLON) begin
                    r = emit(r, CH_COLON);
                    r = emit(r, CH_COLON);
                    r.s.mode = M_VAR;
                end else begin
                    r = end_var(r);
                    if (!r.s.error_seen) begin
                        r = idle_byte(r, CH_COLON);
                        if (!r.s.error_seen) r = var_byte(r, b);
                    end
                end
            end
            M_VAR_PAREN: begin
                if (b == CH_RPAREN) begin
                    r = emit(r, b);
                    r = emit(r, TOK_END);
                    r.s.mode = M_IDLE;
                end else if (b == CH_NUL || is_space(b)) begin
                    r.s.error_seen = 1'b1;
                end else begin
                    r = emit(r, b);
                end
            end
            default: begin
                r = idle_byte(r, b);
            end
        endcase
        return r;
    endfunction

    // Close whatever token is open at the end of the statement.
    function automatic ctx_t lex_finish(ctx_t c);
        ctx_t r;
        r = c;
        if (r.s.error_seen) begin
            return r;
        end
        case (r.s.mode)
            M_BLOCK, M_BLOCK_STAR, M_STRING, M_VAR_PAREN: begin
                r.s.error_seen = 1'b1;
            end
            M_IDENT, M_QPARAM: begin
                r = emit(r, TOK_END);
            end
            M_VAR: begin
                r = end_var(r);
            end
            M_VAR_COLON: begin
                r = end_var(r);
                r.s.error_seen = 1'b1;
            end
            M_IDLE: begin
                if (r.s.held_valid) begin
                    r.s.held_valid = 1'b0;
                    r = token_begin(r, K_SYM, r.s.held_byte);
                end
            end
            default: begin
            end
        endcase
        if (!r.s.error_seen && r.s.comma_pending) begin
            r = emit(r, CH_COMMA);
            r = emit(r, TOK_END);
            r.s.comma_pending = 1'b0;
        end
        return r;
    endfunction

endpackage

FILE: hdl/ssf_datapath.sv
// Datapath: lexer state, hash byte queue, FNV-1a mixer and result register.
module ssf_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ssf_pkg::ssf_cmd_t    cmd,
    output ssf_pkg::ssf_status_t status,
    input  logic [7:0]           data_byte,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [63:0]          shape_key,
    output logic                 failed
);
    import ssf_pkg::*;

    logic [63:0]            hash_reg, hash_next;
    lex_t                   lex_reg, lex_next;
    logic [BYTES_W-1:0]     bytes_reg, bytes_next;
    logic [QDEPTH-1:0][7:0] q_reg, q_next;
    logic [3:0]             n_reg, n_next;
    logic [3:0]             ptr_reg, ptr_next;
    logic                   out_valid_reg, out_valid_next;
    logic [63:0]            key_reg, key_next;
    logic                   failed_reg, failed_next;
    ctx_t                   ctx_in, ctx_out;

    always_comb
    begin
        ctx_in   = '{s: lex_reg, q: '0, n: 4'd0};
        ctx_out  = cmd.load_fin ? lex_finish(ctx_in) : lex_feed(ctx_in, data_byte);

        hash_next      = hash_reg;
        lex_next       = lex_reg;
        bytes_next     = bytes_reg;
        q_next         = q_reg;
        n_next         = n_reg;
        ptr_next       = ptr_reg;
        out_valid_next = out_valid_reg && !out_ready;
        key_next       = key_reg;
        failed_next    = failed_reg;

        if (cmd.load_feed) begin
            ptr_next = 4'd0;
            if (bytes_reg < BYTES_W'(MAX_BYTES)) begin
                lex_next   = ctx_out.s;
                q_next     = ctx_out.q;
                n_next     = ctx_out.n;
                bytes_next = bytes_reg + 1'b1;
            end else begin
                n_next = 4'd0;
            end
        end
        if (cmd.load_fin) begin
            lex_next = ctx_out.s;
            q_next   = ctx_out.q;
            n_next   = ctx_out.n;
            ptr_next = 4'd0;
        end
        if (cmd.mix) begin
            hash_next = fnv_mix(hash_reg, q_reg[ptr_reg[2:0]]);
            ptr_next  = ptr_reg + 4'd1;
        end
        if (cmd.publish) begin
            out_valid_next = 1'b1;
            key_next       = lex_reg.error_seen ? 64'd0 : hash_reg;
            failed_next    = lex_reg.error_seen;
            hash_next      = FNV_BASIS;
            lex_next       = LEX_RESET;
            bytes_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hash_reg      <= FNV_BASIS;
            lex_reg       <= LEX_RESET;
            bytes_reg     <= '0;
            n_reg         <= 4'd0;
            ptr_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
        end else begin
            hash_reg      <= hash_next;
            lex_reg       <= lex_next;
            bytes_reg     <= bytes_next;
            n_reg         <= n_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg      <= q_next;
        key_reg    <= key_next;
        failed_reg <= failed_next;
    end

    assign status.mix_done = (ptr_reg == n_reg);
    assign status.out_busy = out_valid_reg && !out_ready;
    assign out_valid       = out_valid_reg;
    assign shape_key       = key_reg;
    assign failed          = failed_reg;

endmodule

FILE: hdl/ssf_controller.sv
// Controller: sequences byte intake, hash mixing, end-of-statement and result hand-off.
`include "sql_shape_fingerprint_hash_unit_defines.svh"
module ssf_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 last_byte,
    input  ssf_pkg::ssf_status_t status,
    output ssf_pkg::ssf_cmd_t    cmd
);
    import ssf_pkg::*;

    typedef enum logic [1:0] {
        S_IN,
        S_FEED,
        S_FIN_LOAD,
        S_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   last_reg, last_next;

    always_comb
    begin
        state_next = state_reg;
        last_next  = last_reg;
        cmd        = '0;
        case (state_reg)
            S_IN: begin
                if (in_valid) begin
                    cmd.load_feed = 1'b1;
                    last_next     = last_byte;
                    state_next    = S_FEED;
                end
            end
            S_FEED: begin
                if (!status.mix_done) begin
                    cmd.mix = 1'b1;
                end else if (last_reg) begin
                    state_next = S_FIN_LOAD;
                end else begin
                    state_next = S_IN;
                end
            end
            S_FIN_LOAD: begin
                cmd.load_fin = 1'b1;
                state_next   = S_FIN;
            end
            S_FIN: begin
                if (!status.mix_done) begin
                    cmd.mix = 1'b1;
                end else if (!status.out_busy) begin
                    cmd.publish = 1'b1;
                    state_next  = S_IN;
                end
            end
            default: begin
                state_next = S_IN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IN;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            last_reg  <= last_next;
        end
    end

    assign in_ready = (state_reg == S_IN);

    `SSF_ASSERT(a_fin_follows_load, clk, rst_n, cmd.load_fin |=> state_reg == S_FIN)
    `SSF_ASSERT(a_publish_after_last, clk, rst_n, cmd.publish |-> last_reg && status.mix_done)
    `SSF_ASSERT(a_no_mix_on_intake, clk, rst_n, in_ready |-> !cmd.mix && !cmd.publish)
    `SSF_ASSERT_ALWAYS(a_one_load, clk, !(cmd.load_feed && cmd.load_fin))

endmodule

FILE: hdl/sql_shape_fingerprint_hash_unit.sv
// Top level: SQL shape fingerprint hash unit, controller plus datapath.
// Each accepted byte passes through an intake step, one FNV-1a round per cycle on the
// shift-add mixer for each hash byte it emits (0 to 6), and a hand-back step. The byte marked
// last adds a load of its closing bytes (0 to 4) and their rounds before shape_key/failed
// are registered, later while an earlier result still waits.
// Reset (rst_n low, asynchronous) clears the lexer, the hash and the result valid flag.
module sql_shape_fingerprint_hash_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] shape_key,
    output logic        failed
);
    import ssf_pkg::*;

    // Commands and status between the sequencer and the datapath.
    ssf_cmd_t    cmd;
    ssf_status_t status;

    // Sequence each transaction: intake, mix emitted bytes, close on last.
    ssf_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .last_byte (last_byte),
        .status    (status),
        .cmd       (cmd)
    );

    // Hold lexer state and the running hash; drive the output transaction.
    ssf_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .data_byte (data_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .shape_key (shape_key),
        .failed    (failed)
    );

endmodule

FILE: verif/sql_shape_fingerprint_hash_unit_tb.sv
// Self-checking testbench for the SQL shape fingerprint hash unit.
`timescale 1ns / 100ps

module sql_shape_fingerprint_hash_unit_tb;
    import ssf_pkg::*;

    localparam logic [63:0] FNV_PRIME_C = 64'd1099511628211;
    localparam int          STALL_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] shape_key;
    logic        failed;

    // Expected fingerprints, oldest first.
    logic [64:0] key_queue[$];
    int          error_count;
    int          idle_cycles;
    bit          calm_phase;

    // Predictor copy of the lexer state.
    logic [63:0] p_hash;
    lex_mode_t   p_mode;
    logic        p_dquote;
    logic [7:0]  p_held;
    logic        p_held_ok;
    int          p_count;
    logic        p_comma;
    logic [1:0]  p_list;
    logic        p_collapsed;
    logic        p_named;
    logic        p_err;

    sql_shape_fingerprint_hash_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .shape_key (shape_key),
        .failed    (failed)
    );

    always #4 clk = ~clk;

    // ---------------------------------------------------------------
    // Predictor: mirror the lexer one text byte at a time.
    // ---------------------------------------------------------------
    task automatic clear_lexer();
        p_hash = FNV_BASIS;
        p_mode = M_IDLE;
        p_dquote = 1'b0;
        p_held = 8'h00;
        p_held_ok = 1'b0;
        p_count = 0;
        p_comma = 1'b0;
        p_list = LK_NONE;
        p_collapsed = 1'b0;
        p_named = 1'b0;
        p_err = 1'b0;
    endtask

    task automatic fold(input logic [7:0] b);
        p_hash = (p_hash ^ {56'd0, b}) * FNV_PRIME_C;
    endtask

    function automatic bit blank(input logic [7:0] b);
        return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic bit alpha(input logic [7:0] b);
        return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || b == "_";
    endfunction

    function automatic bit digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit name_char(input logic [7:0] b);
        return alpha(b) || digit(b) || b == CH_DOLLAR || b[7];
    endfunction

    function automatic logic [7:0] lower(input logic [7:0] b);
        return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
    endfunction

    // Handle list collapsing at a token start; hash fixed-form tokens.
    task automatic open_token(input logic [2:0] kind, input logic [7:0] sym);
        if (p_comma) begin
            if ((kind == K_NUM && p_list == LK_NUM) || (kind == K_STR && p_list == LK_STR)) begin
                if (!p_collapsed) begin
                    fold(TOK_LIST);
                    fold(TOK_END);
                    p_collapsed = 1'b1;
                end
                p_comma = 1'b0;
                return;
            end
            fold(CH_COMMA);
            fold(TOK_END);
            p_comma = 1'b0;
            p_list = LK_NONE;
            p_collapsed = 1'b0;
        end
        if (kind == K_SYM && sym == CH_COMMA && p_list != LK_NONE) begin
            p_comma = 1'b1;
            return;
        end
        if (kind == K_NUM) begin
            fold(TOK_NUM);
            fold(TOK_END);
        end else if (kind == K_STR) begin
            fold(TOK_STR);
            fold(TOK_END);
        end else if (kind == K_SYM) begin
            fold(sym);
            fold(TOK_END);
        end
        p_list = (kind == K_NUM) ? LK_NUM : (kind == K_STR) ? LK_STR : LK_NONE;
        p_collapsed = 1'b0;
    endtask

    task automatic begin_token(input logic [7:0] b);
        if (b == CH_NUL) begin
            p_err = 1'b1;
        end else if (alpha(b)) begin
            open_token(K_IDENT, CH_NUL);
            fold(lower(b));
            p_mode = M_IDENT;
        end else if (digit(b)) begin
            open_token(K_NUM, CH_NUL);
            p_mode = M_NUMBER;
        end else if (b == CH_SQUOTE || b == CH_DQUOTE) begin
            open_token(K_STR, CH_NUL);
            p_dquote = (b == CH_DQUOTE);
            p_mode = M_STRING;
        end else if (b == CH_QMARK) begin
            open_token(K_PARAM, CH_NUL);
            fold(b);
            p_mode = M_QPARAM;
        end else if (b == CH_AT || b == CH_COLON || b == CH_DOLLAR) begin
            open_token(K_PARAM, CH_NUL);
            fold(b);
            p_named = 1'b0;
            p_mode = M_VAR;
        end else begin
            open_token(K_SYM, b);
        end
    endtask

    task automatic between_tokens(input logic [7:0] b);
        logic [7:0] h;
        p_mode = M_IDLE;
        if (p_held_ok) begin
            h = p_held;
            p_held_ok = 1'b0;
            p_held = 8'h00;
            if (h == CH_DASH && b == CH_DASH) begin
                p_mode = M_LINE;
                return;
            end
            if (h == CH_SLASH && b == CH_STAR) begin
                p_mode = M_BLOCK;
                return;
            end
            open_token(K_SYM, h);
        end
        if (blank(b)) return;
        if (b == CH_DASH || b == CH_SLASH) begin
            p_held = b;
            p_held_ok = 1'b1;
            return;
        end
        begin_token(b);
    endtask

    task automatic close_var();
        if (!p_named) begin
            p_err = 1'b1;
            return;
        end
        fold(TOK_END);
        p_mode = M_IDLE;
    endtask

    task automatic var_step(input logic [7:0] b);
        if (b == CH_NUL) begin
            p_err = 1'b1;
        end else if (name_char(b)) begin
            fold(b);
            p_named = 1'b1;
        end else if (b == CH_LPAREN && p_named) begin
            fold(b);
            p_mode = M_VAR_PAREN;
        end else if (b == CH_COLON) begin
            p_mode = M_VAR_COLON;
        end else begin
            close_var();
            if (!p_err) between_tokens(b);
        end
    endtask

    task automatic lex_byte(input logic [7:0] b);
        logic [7:0] q;
        q = p_dquote ? CH_DQUOTE : CH_SQUOTE;
        if (p_err) return;
        case (p_mode)
            M_LINE: if (b == CH_LF) p_mode = M_IDLE;
            M_BLOCK: if (b == CH_STAR) p_mode = M_BLOCK_STAR;
            M_BLOCK_STAR: begin
                if (b == CH_SLASH) p_mode = M_IDLE;
                else if (b != CH_STAR) p_mode = M_BLOCK;
            end
            M_IDENT: begin
                if (alpha(b) || digit(b)) fold(lower(b));
                else
                begin
                    fold(TOK_END);
                    between_tokens(b);
                end
            end
            M_NUMBER: if (!digit(b)) between_tokens(b);
            M_STRING: begin
                if (b == CH_NUL) p_err = 1'b1;
                else if (b == q) p_mode = M_STRING_Q;
            end
            M_STRING_Q: begin
                if (b == q) p_mode = M_STRING;
                else between_tokens(b);
            end
            M_QPARAM: begin
                if (digit(b)) fold(b);
                else
                begin
                    fold(TOK_END);
                    between_tokens(b);
                end
            end
            M_VAR: var_step(b);
            M_VAR_COLON: begin
                if (b == CH_COLON) begin
                    fold(CH_COLON);
                    fold(CH_COLON);
                    p_mode = M_VAR;
                end else begin
                    close_var();
                    if (!p_err) begin
                        between_tokens(CH_COLON);
                        if (!p_err) var_step(b);
                    end
                end
            end
            M_VAR_PAREN: begin
                if (b == CH_RPAREN) begin
                    fold(b);
                    fold(TOK_END);
                    p_mode = M_IDLE;
                end else if (b == CH_NUL || blank(b)) begin
                    p_err = 1'b1;
                end else begin
                    fold(b);
                end
            end
            default: between_tokens(b);
        endcase
    endtask

    // Close the statement and queue its fingerprint.
    task automatic close_statement();
        if (!p_err) begin
            case (p_mode)
                M_BLOCK, M_BLOCK_STAR, M_STRING, M_VAR_PAREN: p_err = 1'b1;
                M_IDENT, M_QPARAM: fold(TOK_END);
                M_VAR: close_var();
                M_VAR_COLON: begin
                    close_var();
                    p_err = 1'b1;
                end
                M_IDLE: begin
                    if (p_held_ok) begin
                        p_held_ok = 1'b0;
                        open_token(K_SYM, p_held);
                    end
                end
                default: ;
            endcase
            if (!p_err && p_comma) begin
                fold(CH_COMMA);
                fold(TOK_END);
                p_comma = 1'b0;
            end
        end
        key_queue.push_back(p_err ? {1'b1, 64'd0} : {1'b0, p_hash});
        clear_lexer();
    endtask

    // ---------------------------------------------------------------
    // Sender: one byte per transaction, with random idle bursts.
    // ---------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        if (!calm_phase && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 13);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        last_byte <= fin;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (p_count < MAX_BYTES) begin
            lex_byte(b);
            p_count++;
        end
        if (fin) close_statement();
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (key_queue.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    // Random statement built from fragments that reach deep lexer states.
    function automatic string random_fragment();
        case ($urandom_range(0, 19))
            0: return "SELECT ";
            1: return $sformatf("%0d", $urandom_range(0, 99999));
            2: return "'ab''c'";
            3: return "\"x\"";
            4: return ", ";
            5: return "?12";
            6: return "@v1::m(x) ";
            7: return ":nm ";
            8: return "$a$ ";
            9: return "-- note\n";
            10: return "/* c * */";
            11: return "(1,2,3)";
            12: return "('a','b')";
            13: return " ";
            14: return "-x/y";
            15: return "FROM T_1 ";
            16: return "WHERE c=";
            17: return ",,";
            18: return "\t\n";
            default: return ":";
        endcase
    endfunction

    task automatic random_statement();
        int    n;
        string s;
        n = $urandom_range(1, 8);
        s = "";
        for (int i = 0; i < n; i++) s = {s, random_fragment()};
        // Corrupt a few statements with one arbitrary byte each.
        if ($urandom_range(0, 6) == 0) s.putc($urandom_range(0, s.len() - 1), 8'($urandom_range(0, 255)));
        send_text(s);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_tokens();
        send_text("SELECT a_1, B FROM t WHERE x = 42;");
        send_text("x IN (1, 2, 3) AND y IN ('a','b''c',\"d\")");
        send_text("?7 @v :a::b $x(1) @w::");
        send_text("a -- tail\nb /* c */ d - / e,");
        send_text("z");
        send_text("-");
    endtask

    task automatic test_errors();
        send_text("a /* open");
        send_text("/*");
        send_text("'open");
        send_text("@ x");
        send_text("@x(a b)");
        send_text("@x:");
        send_text("a :b:c");
        send_byte(8'h00, 1'b1);
        // NUL inside a string.
        send_byte(CH_SQUOTE, 1'b0);
        send_byte("a", 1'b0);
        send_byte(CH_NUL, 1'b0);
        send_byte(CH_SQUOTE, 1'b1);
    endtask

    task automatic test_bytes();
        // Walk every byte value, high bytes as symbols and variable names.
        for (int i = 0; i < 256; i++) send_byte(i[7:0], i == 255);
        send_text({"@", 8'hFF, 8'h80, " ", 8'hFE});
    endtask

    task automatic test_random();
        for (int i = 0; i < 20; i++) random_statement();
        drain();
        for (int i = 0; i < 12; i++) begin
            for (int j = 0; j < 24; j++) send_byte(8'($urandom_range(0, 255)), 1'b0);
            send_byte(8'($urandom_range(0, 255)), 1'b1);
        end
        for (int i = 0; i < 10; i++) random_statement();
    endtask

    // ---------------------------------------------------------------
    // Result checker and receiver stalls.
    // ---------------------------------------------------------------
    always @(posedge clk) begin
        logic [64:0] want;
        if (rst_n && out_valid && out_ready) begin
            if (key_queue.size() == 0) begin
                $display("%0t unexpected result key=%h failed=%b", $time, shape_key, failed);
                error_count++;
            end else begin
                want = key_queue.pop_front();
                if (shape_key !== want[63:0]) begin
                    $display("%0t shape_key expected %h actual %h", $time, want[63:0], shape_key);
                    error_count++;
                end
                if (failed !== want[64]) begin
                    $display("%0t failed expected %b actual %b", $time, want[64], failed);
                    error_count++;
                end
            end
        end
    end

    initial begin
        int burst;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (!calm_phase && $urandom_range(0, 4) == 0) begin
                out_ready <= 1'b0;
                burst = $urandom_range(1, 13);
                repeat (burst) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT) begin
            $display("[sql_shape_fingerprint_hash_unit] ERROR");
            $finish;
        end else idle_cycles <= idle_cycles + 1;
    end

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        data_byte = 8'h00;
        last_byte = 1'b0;
        error_count = 0;
        idle_cycles = 0;
        calm_phase = 1'b0;
        clear_lexer();
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_tokens();
        test_errors();
        drain();
        test_bytes();
        test_random();
        // Close out with no idling on either side.
        calm_phase = 1'b1;
        for (int i = 0; i < 8; i++) random_statement();

        drain();
        if (error_count == 0) $display("[sql_shape_fingerprint_hash_unit] OK");
        else $display("[sql_shape_fingerprint_hash_unit] ERROR");
        $finish;
    end
endmodule
